[design/lru_key_value_cache_macros.svh]
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms for the cache checker.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Checked on every edge outside reset, clocked by i_clk.
`define LKVC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every edge, reset included.
`define LKVC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[design/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, command codes and the structs shared by the cache modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CAP_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_out_item;

    // Key compare result: one-hot entry that holds the key.
    typedef struct packed {
        logic               hit;
        logic [ENTRIES-1:0] sel;
    } t_match;

    // Entry write request: key and value go to the one-hot entry.
    typedef struct packed {
        logic               en;
        logic [ENTRIES-1:0] sel;
    } t_wr;

endpackage

[design/lkvc_store.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache entry store
// Key and value registers with a parallel key compare across all entries.
// ----------------------------------------------------------------------------
module lkvc_store (
    input  logic                                  i_clk,
    input  logic signed [lkvc_pkg::KEY_W-1:0]     i_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0]     i_value,
    input  logic        [lkvc_pkg::ENTRIES-1:0]   i_valid_vec,
    input  lkvc_pkg::t_wr                         i_wr,
    output lkvc_pkg::t_match                      o_match,
    output logic signed [lkvc_pkg::VAL_W-1:0]     o_read_value
);

    logic signed [lkvc_pkg::KEY_W-1:0] r_keys   [lkvc_pkg::ENTRIES];
    logic signed [lkvc_pkg::VAL_W-1:0] r_values [lkvc_pkg::ENTRIES];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (i_wr.en && i_wr.sel[i]) begin
                r_keys[i]   <= i_key;
                r_values[i] <= i_value;
            end
        end
    end

    // Keys are unique among valid entries, so at most one bit is set and
    // the value can be gathered with an AND-OR mux.
    always_comb begin
        logic [lkvc_pkg::ENTRIES-1:0]      sel;
        logic signed [lkvc_pkg::VAL_W-1:0] val;
        sel = '0;
        val = '0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            sel[i] = i_valid_vec[i] && (r_keys[i] == i_key);
            if (sel[i]) begin
                val = val | r_values[i];
            end
        end
        o_match.sel  = sel;
        o_match.hit  = |sel;
        o_read_value = val;
    end

endmodule

[design/lkvc_lru.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache recency tracker
// Valid bits, recency ranks and fill count; picks the entry to write.
// ----------------------------------------------------------------------------
module lkvc_lru (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic                                i_cmd,
    input  logic [lkvc_pkg::CAP_W-1:0]          i_cap,
    input  lkvc_pkg::t_match                    i_match,
    output logic [lkvc_pkg::ENTRIES-1:0]        o_valid_vec,
    output lkvc_pkg::t_wr                       o_wr
);

    logic [lkvc_pkg::ENTRIES-1:0] r_valid, n_valid;
    logic [lkvc_pkg::IDX_W-1:0]   r_rank [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::IDX_W-1:0]   n_rank [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::CNT_W-1:0]   r_used, n_used;

    logic [lkvc_pkg::CNT_W-1:0]   eff_cap;
    logic                         evict;
    logic                         fill;
    logic                         upd;
    logic [lkvc_pkg::ENTRIES-1:0] victim;
    logic [lkvc_pkg::ENTRIES-1:0] free_vec;
    logic [lkvc_pkg::ENTRIES-1:0] free_sel;
    logic [lkvc_pkg::ENTRIES-1:0] sel;
    logic [lkvc_pkg::IDX_W-1:0]   sel_rank;
    logic [lkvc_pkg::CNT_W-1:0]   thr;

    // Capacity zero acts as one; values above the entry count saturate.
    always_comb begin
        if (i_cap == '0) begin
            eff_cap = lkvc_pkg::CNT_W'(1);
        end else if (32'(i_cap) > 32'(lkvc_pkg::ENTRIES)) begin
            eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
        end else begin
            eff_cap = lkvc_pkg::CNT_W'(i_cap);
        end
    end

    assign evict = (r_used >= eff_cap);

    // Ranks of valid entries are a permutation of 0..used-1, so the least
    // recent entry is the one whose rank equals used-1.
    always_comb begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            victim[i] = r_valid[i] &&
                        ({1'b0, r_rank[i]} == (r_used - lkvc_pkg::CNT_W'(1)));
        end
    end

    // Lowest-numbered free entry.
    assign free_vec = ~r_valid;
    assign free_sel = free_vec & (~free_vec + lkvc_pkg::ENTRIES'(1));

    assign upd  = i_go && (i_match.hit || (i_cmd == lkvc_pkg::CMD_WRITE));
    assign fill = !i_match.hit && !evict;

    always_comb begin
        if (i_match.hit) begin
            sel = i_match.sel;
        end else if (evict) begin
            sel = victim;
        end else begin
            sel = free_sel;
        end
    end

    always_comb begin
        sel_rank = '0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (sel[i]) begin
                sel_rank = sel_rank | r_rank[i];
            end
        end
    end

    // A touched or evicted entry ages only the more recent ones; a fill
    // ages every valid entry.
    assign thr = fill ? lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES) : {1'b0, sel_rank};

    always_comb begin
        n_valid = r_valid;
        n_used  = r_used;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (upd) begin
                if (sel[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && ({1'b0, r_rank[i]} < thr)) begin
                    n_rank[i] = r_rank[i] + lkvc_pkg::IDX_W'(1);
                end
            end
        end
        if (upd && fill) begin
            n_valid = r_valid | sel;
            n_used  = r_used + lkvc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_used  <= n_used;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    assign o_valid_vec = r_valid;
    assign o_wr.en     = i_go && (i_cmd == lkvc_pkg::CMD_WRITE);
    assign o_wr.sel    = sel;

endmodule

[design/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative 32-bit key / 32-bit value store with least-recently-used
// replacement and a configurable capacity.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  in        sink       i_in_valid / o_in_stall  i_in_data  (command, key, value)
//  out       source     o_out_valid / i_out_stall o_out_data (hit, read_value)
//  cfg       sink       i_cfg_we                 i_cfg_data (capacity_in_use)
//
//  One request is taken per cycle while the input is not stalled; it passes
//  from the request register to the result register. Key compare, rank
//  update and entry write are a single pass between those two registers.
//  Reset is synchronous: valid bits, ranks, fill count and capacity (16) clear;
//  keys and values are only read behind valid bits, so they need no clearing.
//  A stalled result holds the request register, which then stalls the input.
//
module lru_key_value_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lkvc_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lkvc_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    i_cfg_data
);

    // Request register (input side) and result register (output side).
    logic                         r_in_valid;
    lkvc_pkg::t_in_item           r_in;
    logic                         r_out_valid;
    lkvc_pkg::t_out_item          r_out;
    lkvc_pkg::t_out_item          n_out;
    logic [lkvc_pkg::CAP_W-1:0]   r_cap;

    logic                         advance;
    logic                         go;
    lkvc_pkg::t_match             match;
    lkvc_pkg::t_wr                wr;
    logic [lkvc_pkg::ENTRIES-1:0] valid_vec;
    logic signed [lkvc_pkg::VAL_W-1:0] hit_value;

    // The result register can take a new result when it is empty or its
    // current result is being transferred this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    lkvc_store u_store (
        .i_clk        (i_clk),
        .i_key        (r_in.key),
        .i_value      (r_in.value),
        .i_valid_vec  (valid_vec),
        .i_wr         (wr),
        .o_match      (match),
        .o_read_value (hit_value)
    );

    lkvc_lru u_lru (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_cmd       (r_in.command),
        .i_cap       (r_cap),
        .i_match     (match),
        .o_valid_vec (valid_vec),
        .o_wr        (wr)
    );

    // A write reports whether the key was present but returns zero; only a
    // lookup hit returns the stored value.
    always_comb begin
        n_out.hit = match.hit;
        if (match.hit && (r_in.command == lkvc_pkg::CMD_LOOKUP)) begin
            n_out.read_value = hit_value;
        end else begin
            n_out.read_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/lkvc_checker.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache port checker
// Watches the top-level ports for handshake and latency behavior.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lkvc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  lkvc_pkg::t_out_item           o_out_data
);

    logic in_xfer;
    logic out_wait;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_wait = o_out_valid && i_out_stall;

    `LKVC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid, "result after reset")
    `LKVC_ASSERT(a_out_hold, out_wait |=> (o_out_valid && $stable(o_out_data)), "result moved")
    `LKVC_ASSERT(a_stall_cause, o_in_stall |-> out_wait, "stall without waiting result")
    `LKVC_ASSERT(a_latency, (in_xfer ##1 !i_out_stall) |=> o_out_valid, "transfer gave no result")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
